[sv/radix_prefixed_integer_parser_assert.svh]
// Assertion macros shared by the parser RTL.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_ASSERT_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RPIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RPIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

[sv/rpip_pkg.sv]
// Types, character constants and character classes for the integer parser.
package rpip_pkg;

	// Parse phases
	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGNED = 3'd1,
		PH_ZERO   = 3'd2,
		PH_PREX   = 3'd3,
		PH_PREB   = 3'd4,
		PH_DIGITS = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	// Number base codes
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               bad_digit;
	} num_beat_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
	localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
	localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
	localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
	localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
	localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
	localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
	localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
	localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [3:0] HEX_TEN  = 4'd10;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	// Digit value of a hex character; only meaningful when is_hex holds
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (is_dec(c))
			d = c - CH_ZERO;
		else if (c >= CH_LA)
			d = c - CH_LA + 8'(HEX_TEN);
		else
			d = c - CH_UA + 8'(HEX_TEN);
		return d[3:0];
	endfunction

	function automatic logic [4:0] radix_base(input radix_t r);
		logic [4:0] b;
		case (r)
			RX_OCT:  b = 5'd8;
			RX_HEX:  b = 5'd16;
			RX_BIN:  b = 5'd2;
			default: b = 5'd10;
		endcase
		return b;
	endfunction

endpackage

[sv/radix_prefixed_integer_parser.sv]
// Top level: streaming parser of signed integer literals with a radix prefix.
//
//  channel    dir  payload                        handshake
//  char_*     in   char_in[7:0], last_char        char_valid / char_stall
//  num_*      out  value[31:0] signed, bad_digit  num_valid / num_stall
//
// One character per cycle sustained while char_stall is low; each beat passes through
// the input register and the phase/accumulator update sits between it and the result.
// A result is computed from its last character in the input register and held in the result register.
// arst_n clears the parse state and both valid flags at once.
// A stalled result holds; further characters keep flowing until another
// last character would need the result register while it is still full.
`include "radix_prefixed_integer_parser_assert.svh"

module radix_prefixed_integer_parser #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  rpip_pkg::char_beat_t   char_beat,
	output logic                   num_valid,
	input  logic                   num_stall,
	output rpip_pkg::num_beat_t    num_beat
);

	localparam int VW = VALUE_WIDTH;

	// input register
	logic                 s1_valid_q;
	rpip_pkg::char_beat_t s1_beat_q;

	// parse state
	rpip_pkg::phase_t phase_q;
	rpip_pkg::radix_t radix_q;
	logic             neg_q;
	logic             err_q;
	logic [VW-1:0]    acc_q;

	// next-state values
	rpip_pkg::phase_t phase_n;
	rpip_pkg::radix_t radix_n;
	logic             neg_n;
	logic             err_n;
	logic [VW-1:0]    acc_n;

	logic             advance;
	logic             out_free;
	logic [7:0]       c;
	logic             do_digit;
	logic [3:0]       dval;
	logic [4:0]       base;
	logic [VW-1:0]    acc_mul;
	logic             err_fin;
	logic [VW-1:0]    val_fin;

	// handshake: only last beats need the result register
	assign out_free   = !num_valid || !num_stall;
	assign advance    = s1_valid_q && (!s1_beat_q.last_char || out_free);
	assign char_stall = s1_valid_q && !advance;

	assign c = s1_beat_q.char_in;

	// one character of the parse
	always_comb begin
		phase_n  = phase_q;
		radix_n  = radix_q;
		neg_n    = neg_q;
		err_n    = err_q;
		do_digit = 1'b0;
		case (phase_q)
			rpip_pkg::PH_LEAD, rpip_pkg::PH_SIGNED: begin
				if (rpip_pkg::is_space(c)) begin
					phase_n = phase_q;
				end else if (phase_q == rpip_pkg::PH_LEAD &&
				             (c == rpip_pkg::CH_MINUS || c == rpip_pkg::CH_PLUS)) begin
					neg_n   = (c == rpip_pkg::CH_MINUS);
					phase_n = rpip_pkg::PH_SIGNED;
				end else if (c == rpip_pkg::CH_ZERO) begin
					phase_n = rpip_pkg::PH_ZERO;
				end else begin
					radix_n  = rpip_pkg::RX_DEC;
					do_digit = 1'b1;
				end
			end
			rpip_pkg::PH_ZERO: begin
				if (c == rpip_pkg::CH_DOT) begin
					radix_n = rpip_pkg::RX_DEC;
					phase_n = rpip_pkg::PH_DONE;
				end else begin
					radix_n = rpip_pkg::RX_OCT;
					if (c == rpip_pkg::CH_LX || c == rpip_pkg::CH_UX)
						phase_n = rpip_pkg::PH_PREX;
					else if (c == rpip_pkg::CH_LB || c == rpip_pkg::CH_UB)
						phase_n = rpip_pkg::PH_PREB;
					else
						do_digit = 1'b1;
				end
			end
			rpip_pkg::PH_PREX: begin
				if (rpip_pkg::is_hex(c)) begin
					radix_n  = rpip_pkg::RX_HEX;
					do_digit = 1'b1;
				end else begin
					phase_n = rpip_pkg::PH_DONE;
				end
			end
			rpip_pkg::PH_PREB: begin
				if (rpip_pkg::is_dec(c)) begin
					radix_n  = rpip_pkg::RX_BIN;
					do_digit = 1'b1;
				end else begin
					// the 'b' falls back to an octal digit of eleven
					err_n   = 1'b1;
					phase_n = rpip_pkg::PH_DONE;
				end
			end
			rpip_pkg::PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
				phase_n = rpip_pkg::PH_DONE;
			end
		endcase

		// digit step in the chosen base
		dval    = rpip_pkg::hex_val(c);
		base    = rpip_pkg::radix_base(radix_n);
		case (radix_n)
			rpip_pkg::RX_OCT: acc_mul = acc_q << 3;
			rpip_pkg::RX_HEX: acc_mul = acc_q << 4;
			rpip_pkg::RX_BIN: acc_mul = acc_q << 1;
			default:          acc_mul = (acc_q << 3) + (acc_q << 1);
		endcase
		acc_n = acc_q;
		if (do_digit) begin
			if (!rpip_pkg::is_hex(c)) begin
				phase_n = rpip_pkg::PH_DONE;
			end else if ({1'b0, dval} >= base) begin
				err_n   = 1'b1;
				phase_n = rpip_pkg::PH_DONE;
			end else begin
				acc_n   = acc_mul + VW'(dval);
				phase_n = rpip_pkg::PH_DIGITS;
			end
		end
	end

	// end of string acts as a NUL: only a pending binary prefix changes
	always_comb begin
		err_fin  = err_n || (phase_n == rpip_pkg::PH_PREB);
		if (err_fin)
			val_fin = '0;
		else if (neg_n)
			val_fin = ~acc_n + VW'(1);
		else
			val_fin = acc_n;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!char_stall) begin
			s1_valid_q <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid)
			s1_beat_q <= char_beat;
	end

	// parse state, back to reset after each last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rpip_pkg::PH_LEAD;
			radix_q <= rpip_pkg::RX_DEC;
			neg_q   <= 1'b0;
			err_q   <= 1'b0;
			acc_q   <= '0;
		end else if (advance) begin
			if (s1_beat_q.last_char) begin
				phase_q <= rpip_pkg::PH_LEAD;
				radix_q <= rpip_pkg::RX_DEC;
				neg_q   <= 1'b0;
				err_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_n;
				radix_q <= radix_n;
				neg_q   <= neg_n;
				err_q   <= err_n;
				acc_q   <= acc_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_valid <= 1'b0;
		end else if (out_free) begin
			num_valid <= advance && s1_beat_q.last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && s1_beat_q.last_char) begin
			num_beat.value     <= signed'(32'(val_fin));
			num_beat.bad_digit <= err_fin;
		end
	end

	// checks
	`RPIP_ASSERT_NOW(a_err_zero, clk, arst_n, num_valid && num_beat.bad_digit,
		num_beat.value == 32'sd0)
	`RPIP_ASSERT_NOW(a_err_done, clk, arst_n, err_q, phase_q == rpip_pkg::PH_DONE)
	`RPIP_ASSERT_NOW(a_stall_full, clk, arst_n, char_stall,
		s1_valid_q && s1_beat_q.last_char && num_valid && num_stall)
	`RPIP_ASSERT_NEXT(a_state_clear, clk, arst_n, advance && s1_beat_q.last_char,
		phase_q == rpip_pkg::PH_LEAD && acc_q == '0 && !neg_q && !err_q)

endmodule

[sim/radix_prefixed_integer_parser_tb.sv]
// Self-checking testbench for the radix-prefixed integer parser.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 8;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 char_valid;
	logic                 char_stall;
	rpip_pkg::char_beat_t char_beat;
	logic                 num_valid;
	logic                 num_stall;
	rpip_pkg::num_beat_t  num_beat;

	radix_prefixed_integer_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.num_valid  (num_valid),
		.num_stall  (num_stall),
		.num_beat   (num_beat)
	);

	// Shadow of the literal being parsed
	rpip_pkg::phase_t    lit_phase;
	logic                lit_negative;
	rpip_pkg::radix_t    lit_radix;
	logic [31:0]         lit_acc;
	logic                lit_bad;

	rpip_pkg::num_beat_t expected_numbers[$];
	logic [7:0]          lit_buf[$];

	int          mismatches;
	int          chars_sent;
	int          literals_sent;
	int          numbers_checked;
	int          bad_digit_seen;
	int          cycle_count;
	int          burst_left;
	int          gap_max;
	stall_mode_t stall_mode;
	bit          hold_request;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Character classes and digit arithmetic
	function automatic bit is_blank(input logic [7:0] c);
		return c == rpip_pkg::CH_SPACE || (c >= rpip_pkg::CH_TAB && c <= rpip_pkg::CH_CR);
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= rpip_pkg::CH_ZERO && c <= rpip_pkg::CH_NINE;
	endfunction

	function automatic bit is_hexdigit(input logic [7:0] c);
		return is_decimal(c) || (c >= rpip_pkg::CH_LA && c <= rpip_pkg::CH_LF) ||
			(c >= rpip_pkg::CH_UA && c <= rpip_pkg::CH_UF);
	endfunction

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		if (is_decimal(c))
			d = c - rpip_pkg::CH_ZERO;
		else if (c >= rpip_pkg::CH_LA)
			d = c - rpip_pkg::CH_LA + 8'd10;
		else
			d = c - rpip_pkg::CH_UA + 8'd10;
		return d[4:0];
	endfunction

	function automatic logic [4:0] base_of(input rpip_pkg::radix_t r);
		case (r)
			rpip_pkg::RX_OCT: return 5'd8;
			rpip_pkg::RX_HEX: return 5'd16;
			rpip_pkg::RX_BIN: return 5'd2;
			default:          return 5'd10;
		endcase
	endfunction

	function automatic void clear_literal();
		lit_phase    = rpip_pkg::PH_LEAD;
		lit_negative = 1'b0;
		lit_radix    = rpip_pkg::RX_DEC;
		lit_acc      = '0;
		lit_bad      = 1'b0;
	endfunction

	// One step of the digit loop; a non-hex char ends the number
	function automatic void take_digit(input logic [7:0] c);
		logic [4:0] b;
		logic [4:0] d;
		b = base_of(lit_radix);
		if (!is_hexdigit(c)) begin
			lit_phase = rpip_pkg::PH_DONE;
			return;
		end
		d = digit_value(c);
		if (d >= b) begin
			lit_bad   = 1'b1;
			lit_phase = rpip_pkg::PH_DONE;
			return;
		end
		lit_acc   = lit_acc * 32'(b) + 32'(d);
		lit_phase = rpip_pkg::PH_DIGITS;
	endfunction

	function automatic void take_first(input logic [7:0] c);
		if (c == rpip_pkg::CH_ZERO) begin
			lit_phase = rpip_pkg::PH_ZERO;
		end else begin
			lit_radix = rpip_pkg::RX_DEC;
			take_digit(c);
		end
	endfunction

	function automatic void advance_literal(input logic [7:0] c);
		case (lit_phase)
			rpip_pkg::PH_LEAD: begin
				if (is_blank(c)) begin
				end else if (c == rpip_pkg::CH_MINUS || c == rpip_pkg::CH_PLUS) begin
					lit_negative = (c == rpip_pkg::CH_MINUS);
					lit_phase    = rpip_pkg::PH_SIGNED;
				end else begin
					take_first(c);
				end
			end
			rpip_pkg::PH_SIGNED: begin
				if (!is_blank(c))
					take_first(c);
			end
			rpip_pkg::PH_ZERO: begin
				if (c == rpip_pkg::CH_DOT) begin
					lit_radix = rpip_pkg::RX_DEC;
					lit_phase = rpip_pkg::PH_DONE;
				end else begin
					lit_radix = rpip_pkg::RX_OCT;
					if (c == rpip_pkg::CH_LX || c == rpip_pkg::CH_UX)
						lit_phase = rpip_pkg::PH_PREX;
					else if (c == rpip_pkg::CH_LB || c == rpip_pkg::CH_UB)
						lit_phase = rpip_pkg::PH_PREB;
					else
						take_digit(c);
				end
			end
			rpip_pkg::PH_PREX: begin
				if (is_hexdigit(c)) begin
					lit_radix = rpip_pkg::RX_HEX;
					take_digit(c);
				end else begin
					lit_phase = rpip_pkg::PH_DONE;
				end
			end
			rpip_pkg::PH_PREB: begin
				// no decimal digit after 0b: the 'b' itself is an octal digit
				if (is_decimal(c)) begin
					lit_radix = rpip_pkg::RX_BIN;
					take_digit(c);
				end else begin
					take_digit(rpip_pkg::CH_LB);
				end
			end
			rpip_pkg::PH_DIGITS: take_digit(c);
			default:             lit_phase = rpip_pkg::PH_DONE;
		endcase
	endfunction

	// Called once per accepted char beat
	function automatic void predict_number(input logic [7:0] c, input logic last);
		rpip_pkg::num_beat_t n;
		advance_literal(c);
		if (last) begin
			advance_literal(8'h00);
			if (lit_bad)
				n.value = '0;
			else if (lit_negative)
				n.value = 32'd0 - lit_acc;
			else
				n.value = lit_acc;
			n.bad_digit = lit_bad;
			expected_numbers.push_back(n);
			literals_sent++;
			clear_literal();
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		rpip_pkg::num_beat_t want;
		if (arst_n && num_valid && !num_stall) begin
			if (expected_numbers.size() == 0) begin
				$error("unexpected num beat: value %0d bad_digit %0b",
					num_beat.value, num_beat.bad_digit);
				mismatches++;
			end else begin
				want = expected_numbers.pop_front();
				numbers_checked++;
				if (num_beat.bad_digit === 1'b1)
					bad_digit_seen++;
				if (num_beat.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, num_beat.value);
					mismatches++;
				end
				if (num_beat.bad_digit !== want.bad_digit) begin
					$error("bad_digit: expected %0b, got %0b",
						want.bad_digit, num_beat.bad_digit);
					mismatches++;
				end
			end
		end
	end

	// Receiver stall pattern, with an occasional long hold-off
	initial begin
		int hold_count;
		num_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				num_stall <= 1'b1;
				for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
					@(posedge clk);
			end
			case (stall_mode)
				STALL_LIGHT: num_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: num_stall <= ($urandom_range(0, 4) != 0);
				STALL_TOGGLE: num_stall <= ~num_stall;
				default:     num_stall <= 1'b0;
			endcase
		end
	end

	// Send one char beat, in bursts separated by random gaps
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		char_valid <= 1'b1;
		char_beat  <= '{char_in: c, last_char: last};
		do
			@(posedge clk);
		while (char_stall);
		burst_left--;
		chars_sent++;
		predict_number(c, last);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_buffer();
		int i;
		for (i = 0; i < lit_buf.size(); i++)
			send_char(lit_buf[i], i == lit_buf.size() - 1);
	endtask

	// Sender stops until every pending number has come back
	task automatic wait_for_results();
		char_valid <= 1'b0;
		burst_left = 0;
		while (expected_numbers.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] any_blank();
		return $urandom_range(0, 1) ? rpip_pkg::CH_SPACE : 8'($urandom_range(9, 13));
	endfunction

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10)
			return 8'(rpip_pkg::CH_ZERO + v);
		return 8'(($urandom_range(0, 1) ? rpip_pkg::CH_LA : rpip_pkg::CH_UA) + v - 10);
	endfunction

	// Mostly well-formed literals with random content; some pure noise
	task automatic build_literal();
		int kind;
		int base;
		int ndig;
		int k;
		lit_buf.delete();
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 4) == 0)
					lit_buf.push_back(8'h00);
				else
					lit_buf.push_back(8'($urandom_range(0, 255)));
			end
			return;
		end
		repeat ($urandom_range(0, 2)) lit_buf.push_back(any_blank());
		case ($urandom_range(0, 3))
			0: lit_buf.push_back(rpip_pkg::CH_MINUS);
			1: lit_buf.push_back(rpip_pkg::CH_PLUS);
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0)
			lit_buf.push_back($urandom_range(0, 1) ? rpip_pkg::CH_MINUS : rpip_pkg::CH_PLUS);
		repeat ($urandom_range(0, 1)) lit_buf.push_back(any_blank());
		kind = $urandom_range(0, 5);
		base = 10;
		case (kind)
			0: lit_buf.push_back(8'(rpip_pkg::CH_ZERO + $urandom_range(1, 9)));
			1: begin
				lit_buf.push_back(rpip_pkg::CH_ZERO);
				base = 8;
			end
			2: begin
				lit_buf.push_back(rpip_pkg::CH_ZERO);
				lit_buf.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LX : rpip_pkg::CH_UX);
				base = 16;
			end
			3: begin
				lit_buf.push_back(rpip_pkg::CH_ZERO);
				lit_buf.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LB : rpip_pkg::CH_UB);
				base = 2;
			end
			4: begin
				lit_buf.push_back(rpip_pkg::CH_ZERO);
				lit_buf.push_back(rpip_pkg::CH_DOT);
			end
			default: ;
		endcase
		// occasional long runs so the accumulator wraps
		ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
		for (k = 0; k < ndig; k++) begin
			if ($urandom_range(0, 15) == 0)
				lit_buf.push_back(digit_char($urandom_range(0, 15)));
			else
				lit_buf.push_back(digit_char($urandom_range(0, base - 1)));
		end
		repeat ($urandom_range(0, 2)) lit_buf.push_back(8'($urandom_range(0, 255)));
		if (lit_buf.size() == 0)
			lit_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Prefixes, signs, blanks and each early-stop path
	task automatic test_directed_literals();
		gap_max    = 0;
		stall_mode = STALL_NONE;
		send_text("9");
		send_text("08");
		send_text("0bz");
		send_text("0xg");
		send_char(8'h35, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'h37, 1'b1);
		send_text("+-1");
		send_text(" ");
		send_text("\t-0B101");
		send_text("0.5");
		send_text("0XaF");
		send_char(8'hFF, 1'b1);
		wait_for_results();
	endtask

	// Long receiver hold-off while short literals keep coming
	task automatic test_output_backpressure();
		int n;
		gap_max    = 0;
		stall_mode = STALL_NONE;
		hold_request = 1'b1;
		for (n = 0; n < 30; n++) begin
			lit_buf.delete();
			lit_buf.push_back(digit_char($urandom_range(0, 9)));
			repeat ($urandom_range(0, 2)) lit_buf.push_back(digit_char($urandom_range(0, 9)));
			send_buffer();
		end
		wait_for_results();
	endtask

	task automatic test_random_literals(input int char_goal, input int gaps,
			input stall_mode_t mode);
		int start;
		gap_max    = gaps;
		stall_mode = mode;
		start      = chars_sent;
		while (chars_sent - start < char_goal) begin
			build_literal();
			send_buffer();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_beat    = '0;
		hold_request = 1'b0;
		stall_mode   = STALL_NONE;
		gap_max      = 0;
		burst_left   = 0;
		clear_literal();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_literals();
		test_output_backpressure();
		test_random_literals(80, 0, STALL_NONE);
		test_random_literals(80, 3, STALL_LIGHT);
		test_random_literals(80, 8, STALL_HEAVY);
		test_random_literals(80, 2, STALL_TOGGLE);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d characters in %0d literals; %0d numbers checked, %0d with a bad digit.",
			chars_sent, literals_sent, numbers_checked, bad_digit_seen);
		$display("Covered blanks, signs, all four bases, early stops and a long output stall.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
